// ===== hdl/mmds_pkg.sv =====
// mmds_pkg: shared types and constants for the motor mode duty sequencer
// holds mode and register codes and the request/response words of the muldiv unit
// no dependencies
`timescale 1ns / 1ps

package mmds_pkg;

	localparam int OPND_W  = 16;
	localparam int PROD_W  = 2 * OPND_W;
	localparam int RECIP_W = PROD_W + 1;

	localparam logic [OPND_W-1:0] PCT_DIVISOR = OPND_W'(100);
	localparam logic [6:0]        PCT_MAX     = 7'd100;

	// rounded-up reciprocal of 100, exact floor for products below 2^23
	localparam int                 PCT_SHIFT = 30;
	localparam logic [RECIP_W-1:0] PCT_RECIP =
		RECIP_W'(((64'd1 << PCT_SHIFT) + 64'(PCT_DIVISOR) - 64'd1) / 64'(PCT_DIVISOR));

	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_LOW    = 3'd1;
	localparam logic [2:0] MODE_HIGH   = 3'd2;
	localparam logic [2:0] MODE_MANUAL = 3'd3;
	localparam logic [2:0] MODE_RAMP   = 3'd4;
	localparam logic [2:0] MODE_NONE   = 3'd5;

	localparam logic [2:0] CFG_MAX_DUTY  = 3'd0;
	localparam logic [2:0] CFG_LOW_PCT   = 3'd1;
	localparam logic [2:0] CFG_HIGH_PCT  = 3'd2;
	localparam logic [2:0] CFG_RAMP_PER  = 3'd3;
	localparam logic [2:0] CFG_RAMP_INC  = 3'd4;

	typedef struct packed {
		logic              start;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		logic              by_pot;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [OPND_W-1:0] quotient;
	} md_rsp_t;

endpackage

// ===== hdl/mmds_muldiv.sv =====
// mmds_muldiv: shared multiplier for floor(a*b/d), d being 100 or the pot full scale
// two passes through one multiplier: a*b, then times the rounded-up reciprocal of d
// depends on mmds_pkg
`timescale 1ns / 1ps

module mmds_muldiv import mmds_pkg::*; #(
	parameter int POT_BITS = 12
) (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	localparam int                 WIDE_W    = PROD_W + RECIP_W;
	localparam int                 POT_SHIFT = 2 * POT_BITS + OPND_W;
	localparam logic [63:0]        POT_DIV   = (64'd1 << POT_BITS) - 64'd1;
	localparam logic [RECIP_W-1:0] POT_RECIP =
		RECIP_W'(((64'd1 << POT_SHIFT) + POT_DIV - 64'd1) / POT_DIV);

	typedef enum logic [2:0] {
		MD_IDLE  = 3'b001,
		MD_MUL   = 3'b010,
		MD_SCALE = 3'b100
	} md_state_t;

	md_state_t         state_q;
	logic              done_q;
	logic [OPND_W-1:0] a_q;
	logic [OPND_W-1:0] b_q;
	logic              by_pot_q;
	logic [PROD_W-1:0] acc_q;
	logic [OPND_W-1:0] quot_q;

	logic [PROD_W-1:0]  mul_x;
	logic [RECIP_W-1:0] mul_y;
	logic [WIDE_W-1:0]  mul_p;

	always_comb begin
		mul_x = PROD_W'(a_q);
		mul_y = RECIP_W'(b_q);
		if (state_q == MD_SCALE) begin
			mul_x = acc_q;
			mul_y = by_pot_q ? POT_RECIP : PCT_RECIP;
		end
	end

	assign mul_p = WIDE_W'(mul_x) * WIDE_W'(mul_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == MD_SCALE);
			case (state_q)
				MD_IDLE: begin
					if (req.start) state_q <= MD_MUL;
				end
				MD_MUL:   state_q <= MD_SCALE;
				MD_SCALE: state_q <= MD_IDLE;
				default:  state_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					a_q      <= req.a;
					b_q      <= req.b;
					by_pot_q <= req.by_pot;
				end
			end
			MD_MUL: begin
				acc_q <= mul_p[PROD_W-1:0];
			end
			MD_SCALE: begin
				// reciprocal error stays below one step, so the shift gives the floor
				quot_q <= by_pot_q ? mul_p[POT_SHIFT +: OPND_W] : mul_p[PCT_SHIFT +: OPND_W];
			end
			default: ;
		endcase
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

// ===== hdl/motor_mode_duty_sequencer.sv =====
// motor_mode_duty_sequencer: button debounce, mode cycling and pwm duty per tick
// sequencer around the shared mmds_muldiv unit; depends on mmds_pkg
//
//   channel  handshake            payload
//   in       in_valid/in_ready    button_pressed, pot_sample
//   out      out_valid/out_ready  duty, run_mode, drive_enable
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// each tick runs the muldiv unit for the low level, the high level and, in manual mode,
// the pot scaling, then steps through ramp entry, ramp step and output load, and ends
// in the idle state that accepts a word
// in_ready is high only while the sequencer is idle; cfg_ready is always high
// a result waiting in the output register stalls only the final load of the next tick
// arst_n clears all control state and restores register defaults
`timescale 1ns / 1ps

module motor_mode_duty_sequencer import mmds_pkg::*; #(
	parameter int DEBOUNCE_LEN = 31,
	parameter int POT_BITS     = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        button_pressed,
	input  logic [11:0] pot_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] duty,
	output logic [2:0]  run_mode,
	output logic        drive_enable,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int               HIST_W    = DEBOUNCE_LEN + 1;
	localparam logic [HIST_W-1:0] DB_TARGET = {1'b0, {DEBOUNCE_LEN{1'b1}}};
	localparam logic [15:0]      POT_FULL  = 16'((32'd1 << POT_BITS) - 32'd1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LO    = 7'b0000010,
		ST_HI    = 7'b0000100,
		ST_MAN   = 7'b0001000,
		ST_ENTRY = 7'b0010000,
		ST_STEP  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} seq_state_t;

	seq_state_t state_q;

	logic [15:0] max_duty_q;
	logic [6:0]  low_pct_q;
	logic [6:0]  high_pct_q;
	logic [7:0]  ramp_per_q;
	logic [7:0]  ramp_inc_q;

	logic [31:0]       tick_q;
	logic [HIST_W-1:0] hist_q;
	logic              await_q;
	logic [2:0]        mode_q;
	logic [2:0]        prev_q;
	logic [15:0]       ramp_level_q;
	logic              rising_q;
	logic [31:0]       ramp_last_q;

	logic [11:0] pot_q;
	logic [15:0] lo_q;
	logic [15:0] hi_q;
	logic [15:0] man_q;

	logic        out_valid_q;
	logic [15:0] duty_q;
	logic [2:0]  out_mode_q;
	logic        en_q;

	md_req_t req;
	md_rsp_t rsp;

	logic              in_fire;
	logic              out_load;
	logic [HIST_W-1:0] hist_next;
	logic [2:0]        mode_adv;
	logic [6:0]        low_pct_c;
	logic [6:0]        high_pct_c;
	logic [15:0]       pot_ext;
	logic [15:0]       pot_c;
	logic              step_due;
	logic signed [17:0] next_s;
	logic signed [17:0] lo_s;
	logic signed [17:0] hi_s;
	logic [15:0]       duty_sel;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign hist_next  = {hist_q[HIST_W-2:0], button_pressed};
	assign mode_adv   = (mode_q == MODE_RAMP) ? MODE_OFF : mode_q + 3'd1;
	assign low_pct_c  = (low_pct_q > PCT_MAX) ? PCT_MAX : low_pct_q;
	assign high_pct_c = (high_pct_q > PCT_MAX) ? PCT_MAX : high_pct_q;
	assign pot_ext    = 16'(pot_q);
	assign pot_c      = (pot_ext > POT_FULL) ? POT_FULL : pot_ext;

	// muldiv requests: low level, high level, pot scaling
	always_comb begin
		req.start  = 1'b0;
		req.a      = 16'(low_pct_c);
		req.b      = max_duty_q;
		req.by_pot = 1'b0;
		case (state_q)
			ST_IDLE: req.start = in_fire;
			ST_LO: begin
				req.start = rsp.done;
				req.a     = 16'(high_pct_c);
			end
			ST_HI: begin
				req.start  = rsp.done && (mode_q == MODE_MANUAL);
				req.a      = pot_c;
				req.b      = rsp.quotient;
				req.by_pot = 1'b1;
			end
			default: ;
		endcase
	end

	mmds_muldiv #(
		.POT_BITS (POT_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign step_due = (tick_q - ramp_last_q) >= {24'd0, ramp_per_q};
	assign lo_s     = $signed({2'b00, lo_q});
	assign hi_s     = $signed({2'b00, hi_q});
	assign next_s   = rising_q
		? $signed({2'b00, ramp_level_q}) + $signed({10'd0, ramp_inc_q})
		: $signed({2'b00, ramp_level_q}) - $signed({10'd0, ramp_inc_q});

	always_comb begin
		case (mode_q)
			MODE_LOW:    duty_sel = lo_q;
			MODE_HIGH:   duty_sel = hi_q;
			MODE_MANUAL: duty_sel = man_q;
			MODE_RAMP:   duty_sel = ramp_level_q;
			default:     duty_sel = 16'd0;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q <= 16'd1000;
			low_pct_q  <= 7'd50;
			high_pct_q <= 7'd80;
			ramp_per_q <= 8'd15;
			ramp_inc_q <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_DUTY: max_duty_q <= cfg_data;
				CFG_LOW_PCT:  low_pct_q  <= cfg_data[6:0];
				CFG_HIGH_PCT: high_pct_q <= cfg_data[6:0];
				CFG_RAMP_PER: ramp_per_q <= cfg_data[7:0];
				CFG_RAMP_INC: ramp_inc_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer and tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			hist_q       <= '0;
			await_q      <= 1'b1;
			mode_q       <= MODE_OFF;
			prev_q       <= MODE_NONE;
			ramp_level_q <= '0;
			rising_q     <= 1'b0;
			ramp_last_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						tick_q <= tick_q + 32'd1;
						if (await_q) begin
							if (!button_pressed) begin
								await_q <= 1'b0;
								hist_q  <= '0;
							end
						end else if (hist_next == DB_TARGET) begin
							mode_q  <= mode_adv;
							hist_q  <= '0;
							await_q <= 1'b1;
						end else begin
							hist_q <= hist_next;
						end
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					if (rsp.done) state_q <= ST_HI;
				end
				ST_HI: begin
					if (rsp.done) state_q <= (mode_q == MODE_MANUAL) ? ST_MAN : ST_ENTRY;
				end
				ST_MAN: begin
					if (rsp.done) state_q <= ST_ENTRY;
				end
				ST_ENTRY: begin
					if (mode_q != prev_q) begin
						if (mode_q == MODE_RAMP) begin
							ramp_level_q <= lo_q;
							rising_q     <= 1'b1;
							ramp_last_q  <= tick_q;
						end
						prev_q <= mode_q;
					end
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (mode_q == MODE_RAMP && step_due) begin
						ramp_last_q <= tick_q;
						if (next_s >= hi_s) begin
							ramp_level_q <= hi_q;
							rising_q     <= 1'b0;
						end else if (next_s <= lo_s) begin
							ramp_level_q <= lo_q;
							rising_q     <= 1'b1;
						end else begin
							ramp_level_q <= next_s[15:0];
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) pot_q <= pot_sample;
		if (state_q == ST_LO && rsp.done) lo_q <= rsp.quotient;
		if (state_q == ST_HI && rsp.done) hi_q <= rsp.quotient;
		if (state_q == ST_MAN && rsp.done) man_q <= rsp.quotient;
		if (out_load) begin
			duty_q     <= duty_sel;
			out_mode_q <= mode_q;
			en_q       <= (mode_q != MODE_OFF);
		end
	end

	assign out_valid    = out_valid_q;
	assign duty         = duty_q;
	assign run_mode     = out_mode_q;
	assign drive_enable = en_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_LO || state_q == ST_HI || state_q == ST_MAN))
		else $error("muldiv finished while sequencer was not waiting");

	a_out_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_mode <= MODE_RAMP && drive_enable == (run_mode != MODE_OFF)))
		else $error("output word mode or enable inconsistent");

	a_mode_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != $past(mode_q)) |-> $past(in_valid && in_ready))
		else $error("mode changed without an accepted tick");

endmodule
